/* hdl/dbs_pkg.sv */
`default_nettype none

package dbs_pkg;

    // defaults for the top-level parameters
    localparam int DBS_MAX_ORDER       = 8;
    localparam int DBS_COS_TABLE_DEPTH = 256;

    // register reset values
    localparam logic [3:0]  DBS_ORDER_RST = 4'd4;
    localparam logic [15:0] DBS_INV_RST   = 16'd256;

    // register indexes (word address bit 2)
    localparam logic DBS_REG_ORDER = 1'b0;
    localparam logic DBS_REG_INV   = 1'b1;

    // pi/2 in Q30
    localparam logic [63:0] DBS_HALF_PI_Q30 = 64'd1686629713;

    // unit value in Q1.14
    localparam logic [14:0] DBS_ONE_Q14 = 15'd16384;

    // tag that travels with each item down the pipeline
    typedef struct packed {
        logic       vld;
        logic       last;
        logic [5:0] idx;
    } dbs_tag_t;

    // clamp the order register into 1..max_order
    function automatic logic [3:0] dbs_clamp_order(input logic [3:0] v, input int max_order);
        logic [3:0] r;
        r = v;
        if (v == 4'd0) begin
            r = 4'd1;
        end else if (v > 4'(max_order)) begin
            r = 4'(max_order);
        end
        return r;
    endfunction

    // Q30 taylor series of cos, rounded half up to Q1.14 and clamped
    function automatic logic [14:0] dbs_series_cos(input logic [63:0] a);
        logic [63:0]        a2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        rnd;
        a2   = (a * a) >> 30;
        term = 64'd1 << 30;
        sum  = signed'(term);
        for (int k = 1; k <= 10; k++) begin
            term = (term * a2) >> 30;
            case (k)
                1: begin
                    term = term / 64'd2;
                end
                2: begin
                    term = term / 64'd12;
                end
                3: begin
                    term = term / 64'd30;
                end
                4: begin
                    term = term / 64'd56;
                end
                5: begin
                    term = term / 64'd90;
                end
                6: begin
                    term = term / 64'd132;
                end
                7: begin
                    term = term / 64'd182;
                end
                8: begin
                    term = term / 64'd240;
                end
                9: begin
                    term = term / 64'd306;
                end
                default: begin
                    term = term / 64'd380;
                end
            endcase
            if ((k % 2) == 1) begin
                sum = sum - signed'(term);
            end else begin
                sum = sum + signed'(term);
            end
        end
        if (sum <= 64'sd0) begin
            return 15'd0;
        end
        rnd = (unsigned'(sum) + (64'd1 << 15)) >> 16;
        if (rnd > 64'(DBS_ONE_Q14)) begin
            rnd = 64'(DBS_ONE_Q14);
        end
        return 15'(rnd);
    endfunction

endpackage

`default_nettype wire

/* hdl/dct_basis_sampler.sv */
// channel   direction  handshake            payload
// s_        in         s_tvalid / s_tready   tdata: x_coord [15:0], y_coord [31:16]
// m_        out        m_tvalid / m_tready   tdata: basis_value [15:0], basis_index [21:16];
//                                            tlast: last
// apb       in         psel/penable, pready  basis_order @0x0, inv_radius @0x4
//
// A point yields order*order results (1 to 64) from the frequency sequencer, one result
// per cycle unless the output stalls; the next point is taken in the cycle the last pair leaves it.
// Each result passes the sequencer, the phase stages, the table read, the product and the output register.
// Reset clears the sequencer and all stage valid bits; config goes to its reset values.
// A stalled output freezes every stage, so nothing is dropped or repeated.
`default_nettype none

module dct_basis_sampler #(
    parameter int MAX_ORDER       = dbs_pkg::DBS_MAX_ORDER,
    parameter int COS_TABLE_DEPTH = dbs_pkg::DBS_COS_TABLE_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // x_coord [15:0], y_coord [31:16]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // basis_value [15:0], basis_index [21:16], zeros
    output logic             m_tlast
);
    import dbs_pkg::*;

    localparam int F_W    = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int TIDX_W = $clog2(COS_TABLE_DEPTH + 1);

    logic [3:0]        basis_order_reg;
    logic [15:0]       inv_radius_reg;
    logic              adv;
    logic              cfg_wr;
    dbs_tag_t          tag0, tag3, tag4;
    logic [15:0]       x0, y0;
    logic [F_W-1:0]    fx0, fy0;
    logic [TIDX_W-1:0] ax3, ay3;
    logic              nx3, ny3, nx4, ny4;
    logic [14:0]       cx4, cy4;

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            basis_order_reg <= DBS_ORDER_RST;
            inv_radius_reg  <= DBS_INV_RST;
        end else if (cfg_wr) begin
            case (paddr[2])
                DBS_REG_ORDER: begin
                    basis_order_reg <= pwdata[3:0];
                end
                DBS_REG_INV: begin
                    inv_radius_reg <= pwdata[15:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            DBS_REG_ORDER: begin
                prdata = 32'(basis_order_reg);
            end
            DBS_REG_INV: begin
                prdata = 32'(inv_radius_reg);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    // whole pipeline moves when the output register is free
    assign adv = !m_tvalid || m_tready;

    dbs_seq #(
        .MAX_ORDER(MAX_ORDER)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adv        (adv),
        .basis_order(basis_order_reg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .tag_out    (tag0),
        .x_out      (x0),
        .y_out      (y0),
        .fx_out     (fx0),
        .fy_out     (fy0)
    );

    dbs_phase #(
        .MAX_ORDER      (MAX_ORDER),
        .COS_TABLE_DEPTH(COS_TABLE_DEPTH)
    ) u_phase (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .inv_radius(inv_radius_reg),
        .tag_in    (tag0),
        .x_in      (x0),
        .y_in      (y0),
        .fx_in     (fx0),
        .fy_in     (fy0),
        .tag_out   (tag3),
        .addr_x    (ax3),
        .addr_y    (ay3),
        .neg_x     (nx3),
        .neg_y     (ny3)
    );

    dbs_cos #(
        .COS_TABLE_DEPTH(COS_TABLE_DEPTH)
    ) u_cos (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .tag_in  (tag3),
        .addr_x  (ax3),
        .addr_y  (ay3),
        .neg_x_in(nx3),
        .neg_y_in(ny3),
        .tag_out (tag4),
        .cos_x   (cx4),
        .cos_y   (cy4),
        .neg_x   (nx4),
        .neg_y   (ny4)
    );

    dbs_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .tag_in  (tag4),
        .cos_x   (cx4),
        .cos_y   (cy4),
        .neg_x   (nx4),
        .neg_y   (ny4),
        .m_tvalid(m_tvalid),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

`ifndef SYNTH
    // a new point is only taken while the pipeline is moving
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (!m_tvalid || m_tready))
        else $error("input taken while pipeline stalled");

    // result stays within one in Q1.14
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[15:0]) <= 16'sd16384 &&
                      $signed(m_tdata[15:0]) >= -16'sd16384))
        else $error("basis value out of range");

    // last result of a point carries the top index for the order
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tdata[21:16] ==
            6'(8'(dbs_clamp_order(basis_order_reg, MAX_ORDER)) *
               8'(dbs_clamp_order(basis_order_reg, MAX_ORDER)) - 8'd1)))
        else $error("last flag on wrong index");
`endif

endmodule

`default_nettype wire

/* hdl/dbs_seq.sv */
`default_nettype none

module dbs_seq #(
    parameter  int MAX_ORDER = 8,
    localparam int F_W       = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             adv,
    input  wire logic [3:0]       basis_order,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [31:0]      s_tdata,   // x_coord [15:0], y_coord [31:16]
    output dbs_pkg::dbs_tag_t     tag_out,
    output logic [15:0]           x_out,
    output logic [15:0]           y_out,
    output logic [F_W-1:0]        fx_out,
    output logic [F_W-1:0]        fy_out
);
    import dbs_pkg::*;

    localparam int ORD_W = $clog2(MAX_ORDER + 1);
    localparam int IDX_W = (MAX_ORDER > 1) ? $clog2(MAX_ORDER * MAX_ORDER) : 1;

    logic             busy_reg, busy_next;
    logic [15:0]      x_reg, x_next;
    logic [15:0]      y_reg, y_next;
    logic [F_W-1:0]   fx_reg, fx_next;
    logic [F_W-1:0]   fy_reg, fy_next;
    logic [ORD_W-1:0] ord_reg, ord_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [F_W-1:0]   f_top;
    logic             fy_wrap;
    logic             at_last;
    logic             accept;
    logic             emit;

    // end of a row and end of the point
    assign f_top    = F_W'(ord_reg - 1'b1);
    assign fy_wrap  = (fy_reg == f_top);
    assign at_last  = fy_wrap && (fx_reg == f_top);
    assign s_tready = adv && (!busy_reg || at_last);
    assign accept   = s_tvalid && s_tready;
    assign emit     = adv && busy_reg;

    // frequency counters, fy inner
    always_comb begin
        busy_next = busy_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        fx_next   = fx_reg;
        fy_next   = fy_reg;
        ord_next  = ord_reg;
        idx_next  = idx_reg;
        if (accept) begin
            busy_next = 1'b1;
            x_next    = s_tdata[15:0];
            y_next    = s_tdata[31:16];
            fx_next   = '0;
            fy_next   = '0;
            idx_next  = '0;
            ord_next  = ORD_W'(dbs_clamp_order(basis_order, MAX_ORDER));
        end else if (emit) begin
            if (at_last) begin
                busy_next = 1'b0;
            end else if (fy_wrap) begin
                fy_next  = '0;
                fx_next  = fx_reg + 1'b1;
                idx_next = idx_reg + 1'b1;
            end else begin
                fy_next  = fy_reg + 1'b1;
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        x_reg   <= x_next;
        y_reg   <= y_next;
        fx_reg  <= fx_next;
        fy_reg  <= fy_next;
        ord_reg <= ord_next;
        idx_reg <= idx_next;
    end

    // current pair feeds the first stage
    assign tag_out.vld  = busy_reg;
    assign tag_out.last = at_last;
    assign tag_out.idx  = 6'(idx_reg);
    assign x_out        = x_reg;
    assign y_out        = y_reg;
    assign fx_out       = fx_reg;
    assign fy_out       = fy_reg;

endmodule

`default_nettype wire

/* hdl/dbs_phase.sv */
`default_nettype none

module dbs_phase #(
    parameter  int MAX_ORDER       = 8,
    parameter  int COS_TABLE_DEPTH = 256,
    localparam int F_W             = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1,
    localparam int TIDX_W          = $clog2(COS_TABLE_DEPTH + 1)
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               adv,
    input  wire logic [15:0]        inv_radius,
    input  wire dbs_pkg::dbs_tag_t  tag_in,
    input  wire logic [15:0]        x_in,
    input  wire logic [15:0]        y_in,
    input  wire logic [F_W-1:0]     fx_in,
    input  wire logic [F_W-1:0]     fy_in,
    output dbs_pkg::dbs_tag_t       tag_out,
    output logic [TIDX_W-1:0]       addr_x,
    output logic [TIDX_W-1:0]       addr_y,
    output logic                    neg_x,
    output logic                    neg_y
);
    import dbs_pkg::*;

    localparam logic [TIDX_W-1:0] DEPTH_C = TIDX_W'(COS_TABLE_DEPTH);

    dbs_tag_t            tag1_reg, tag2_reg, tag3_reg;
    logic [16:0]         stx_reg, sty_reg;
    logic [F_W-1:0]      fx1_reg, fy1_reg;
    logic [16:0]         phx_reg, phy_reg;
    logic [TIDX_W-1:0]   ax_reg, ay_reg;
    logic                nx_reg, ny_reg;
    logic [32:0]         stx_full, sty_full;
    logic [16+F_W:0]     phx_full, phy_full;
    logic [14+TIDX_W:0]  scx, scy;
    logic [TIDX_W-1:0]   ix, iy;

    // coordinate times reciprocal, kept modulo two half-turns
    assign stx_full = {x_in[15], x_in} * inv_radius;
    assign sty_full = {y_in[15], y_in} * inv_radius;

    // times frequency
    assign phx_full = stx_reg * fx1_reg;
    assign phy_full = sty_reg * fy1_reg;

    // quarter-turn fraction scaled to a table index
    assign scx = phx_reg[14:0] * DEPTH_C;
    assign scy = phy_reg[14:0] * DEPTH_C;
    assign ix  = scx[14+TIDX_W:15];
    assign iy  = scy[14+TIDX_W:15];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
        end else if (adv) begin
            tag1_reg <= tag_in;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            stx_reg <= stx_full[16:0];
            sty_reg <= sty_full[16:0];
            fx1_reg <= fx_in;
            fy1_reg <= fy_in;
            phx_reg <= phx_full[16:0];
            phy_reg <= phy_full[16:0];
            // odd quadrants mirror the index, middle two negate
            ax_reg  <= phx_reg[15] ? (DEPTH_C - ix) : ix;
            ay_reg  <= phy_reg[15] ? (DEPTH_C - iy) : iy;
            nx_reg  <= phx_reg[16] ^ phx_reg[15];
            ny_reg  <= phy_reg[16] ^ phy_reg[15];
        end
    end

    assign tag_out = tag3_reg;
    assign addr_x  = ax_reg;
    assign addr_y  = ay_reg;
    assign neg_x   = nx_reg;
    assign neg_y   = ny_reg;

endmodule

`default_nettype wire

/* hdl/dbs_cos.sv */
`default_nettype none

module dbs_cos #(
    parameter  int COS_TABLE_DEPTH = 256,
    localparam int TIDX_W          = $clog2(COS_TABLE_DEPTH + 1)
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               adv,
    input  wire dbs_pkg::dbs_tag_t  tag_in,
    input  wire logic [TIDX_W-1:0]  addr_x,
    input  wire logic [TIDX_W-1:0]  addr_y,
    input  wire logic               neg_x_in,
    input  wire logic               neg_y_in,
    output dbs_pkg::dbs_tag_t       tag_out,
    output logic [14:0]             cos_x,
    output logic [14:0]             cos_y,
    output logic                    neg_x,
    output logic                    neg_y
);
    import dbs_pkg::*;

    typedef logic [14:0] rom_t [COS_TABLE_DEPTH+1];

    // quarter-wave table, entry i is cos(pi/2*i/depth) in Q1.14
    function automatic rom_t build_rom();
        rom_t        r;
        logic [63:0] a;
        for (int i = 0; i <= COS_TABLE_DEPTH; i++) begin
            a    = (64'(i) * DBS_HALF_PI_Q30) / COS_TABLE_DEPTH;
            r[i] = dbs_series_cos(a);
        end
        return r;
    endfunction

    localparam rom_t COS_ROM = build_rom();

    dbs_tag_t    tag_reg;
    logic [14:0] cx_reg, cy_reg;
    logic        nx_reg, ny_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg <= '0;
        end else if (adv) begin
            tag_reg <= tag_in;
        end
    end

    // registered table reads, one port per axis
    always_ff @(posedge aclk) begin
        if (adv) begin
            cx_reg <= COS_ROM[addr_x];
            cy_reg <= COS_ROM[addr_y];
            nx_reg <= neg_x_in;
            ny_reg <= neg_y_in;
        end
    end

    assign tag_out = tag_reg;
    assign cos_x   = cx_reg;
    assign cos_y   = cy_reg;
    assign neg_x   = nx_reg;
    assign neg_y   = ny_reg;

endmodule

`default_nettype wire

/* hdl/dbs_mul.sv */
`default_nettype none

module dbs_mul (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               adv,
    input  wire dbs_pkg::dbs_tag_t  tag_in,
    input  wire logic [14:0]        cos_x,
    input  wire logic [14:0]        cos_y,
    input  wire logic               neg_x,
    input  wire logic               neg_y,
    output logic                    m_tvalid,
    output logic [23:0]             m_tdata,   // basis_value [15:0], basis_index [21:16]
    output logic                    m_tlast
);
    import dbs_pkg::*;

    dbs_tag_t    tag_reg;
    logic [29:0] mag_reg;
    logic        sgn_reg;
    logic        ov_reg;
    logic        ol_reg;
    logic [5:0]  oi_reg;
    logic [15:0] ovl_reg;
    logic [29:0] rsum;
    logic [14:0] rmag;
    logic [15:0] sval;

    // round half away from zero to Q1.14
    assign rsum = mag_reg + 30'd8192;
    assign rmag = rsum[28:14];
    assign sval = sgn_reg ? (16'd0 - {1'b0, rmag}) : {1'b0, rmag};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg <= '0;
            ov_reg  <= 1'b0;
        end else if (adv) begin
            tag_reg <= tag_in;
            ov_reg  <= tag_reg.vld;
        end
    end

    // magnitude product, then output register
    always_ff @(posedge aclk) begin
        if (adv) begin
            mag_reg <= cos_x * cos_y;
            sgn_reg <= neg_x ^ neg_y;
            ol_reg  <= tag_reg.last;
            oi_reg  <= tag_reg.idx;
            ovl_reg <= sval;
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tlast  = ol_reg;
    assign m_tdata  = {2'b00, oi_reg, ovl_reg};

endmodule

`default_nettype wire

/* verif/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dbs_pkg::*;

    localparam int          COS_DEPTH     = DBS_COS_TABLE_DEPTH;
    localparam int          ORDER_CAP     = DBS_MAX_ORDER;
    localparam int          SETTLE_CYCLES = 12;
    localparam int          HOLD_CYCLES   = 400;
    localparam int          LIMIT_CYCLES  = 600000;
    localparam int          SHOW_MAX      = 10;

    typedef enum logic [1:0] {QUAD_FIRST, QUAD_SECOND, QUAD_THIRD, QUAD_FOURTH} quad_t;
    typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PATTERN} rx_mode_t;

    typedef struct packed {
        logic [15:0] value;
        logic [5:0]  index;
        logic        last;
    } basis_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // x_coord [15:0], y_coord [31:16]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;         // basis_value [15:0], basis_index [21:16], zeros
    logic        m_tlast;

    // cosine quarter-wave table and register copies
    int          cos_q14 [0:COS_DEPTH];
    logic [3:0]  model_order;
    logic [15:0] model_inv;

    basis_t      pending_basis [$];

    int          points_taken   = 0;
    int          values_checked = 0;
    int          bad_results    = 0;
    int          settings_used  = 0;
    int          cycle          = 0;

    // sender burst state
    int          burst_left = 0;
    bit          gaps_on    = 1'b1;

    // receiver control
    rx_mode_t    rx_mode   = RX_ALWAYS;
    logic        hold_trig = 1'b0;
    logic        hold_seen;
    int          hold_cnt;
    logic [15:0] rx_pat;

    dct_basis_sampler i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycle <= cycle + 1;
        if (cycle >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d basis values outstanding",
                     cycle, pending_basis.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // cosine in q1.14 from an 11-term q30 series, rounded half up
    function automatic int series_cos_q14(input longint unsigned ang);
        longint unsigned a2;
        longint unsigned term;
        longint unsigned rnd;
        longint          acc;
        a2   = (ang * ang) >> 30;
        term = 64'd1 << 30;
        acc  = longint'(term);
        for (int k = 1; k <= 10; k++) begin
            term = (term * a2) >> 30;
            term = term / longint'((2 * k - 1) * (2 * k));
            if (k % 2 == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        if (acc <= 0) begin
            return 0;
        end
        rnd = (unsigned'(acc) + (64'd1 << 15)) >> 16;
        if (rnd > 64'd16384) begin
            rnd = 64'd16384;
        end
        return int'(rnd);
    endfunction

    task automatic build_cos_rom();
        for (int i = 0; i <= COS_DEPTH; i++) begin
            cos_q14[i] = series_cos_q14((64'(i) * DBS_HALF_PI_Q30) / COS_DEPTH);
        end
    endtask

    // phase in q16.16 half-turns, taken modulo one full turn
    function automatic int cos_of_phase(input longint ph);
        logic [16:0] p;
        int          idx;
        p   = ph[16:0];
        idx = int'((longint'(p[14:0]) * COS_DEPTH) >> 15);
        case (quad_t'(p[16:15]))
            QUAD_FIRST:  return cos_q14[idx];
            QUAD_SECOND: return -cos_q14[COS_DEPTH - idx];
            QUAD_THIRD:  return -cos_q14[idx];
            default:     return cos_q14[COS_DEPTH - idx];
        endcase
    endfunction

    // all basis values for one point under the current registers
    task automatic compute_basis_set(input logic signed [15:0] xc, input logic signed [15:0] yc);
        int     eff;
        int     cx;
        int     cy;
        longint xs;
        longint ys;
        longint inv;
        longint prod;
        longint mag;
        longint val;
        basis_t b;
        eff = int'(model_order);
        if (eff < 1) begin
            eff = 1;
        end
        if (eff > ORDER_CAP) begin
            eff = ORDER_CAP;
        end
        xs  = xc;
        ys  = yc;
        inv = longint'(model_inv);
        for (int fx = 0; fx < eff; fx++) begin
            cx = cos_of_phase(xs * fx * inv);
            for (int fy = 0; fy < eff; fy++) begin
                cy   = cos_of_phase(ys * fy * inv);
                prod = longint'(cx) * longint'(cy);
                mag  = (prod < 0) ? -prod : prod;
                val  = (mag + 8192) >>> 14;
                if (prod < 0) begin
                    val = -val;
                end
                b.value = val[15:0];
                b.index = 6'(fx * eff + fy);
                b.last  = (fx == eff - 1) && (fy == eff - 1);
                pending_basis.push_back(b);
            end
        end
    endtask

    // predict on every accepted point
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            compute_basis_set(s_tdata[15:0], s_tdata[31:16]);
            points_taken++;
        end
    end

    // compare each accepted basis value with the oldest prediction
    always @(posedge aclk) begin : basis_check
        basis_t got;
        basis_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.value = m_tdata[15:0];
            got.index = m_tdata[21:16];
            got.last  = m_tlast;
            values_checked++;
            if (pending_basis.size() == 0) begin
                if (bad_results < SHOW_MAX) begin
                    $display("unexpected basis value %0d index %0d last %0b",
                             $signed(got.value), got.index, got.last);
                end
                bad_results++;
            end else begin
                want = pending_basis.pop_front();
                if (got.value !== want.value || got.index !== want.index ||
                    got.last !== want.last) begin
                    if (bad_results < SHOW_MAX) begin
                        $display("mismatch: value exp %0d got %0d, index exp %0d got %0d, last exp %0b got %0b",
                                 $signed(want.value), $signed(got.value), want.index,
                                 got.index, want.last, got.last);
                    end
                    bad_results++;
                end
            end
        end
    end

    // receiver: long hold-off on request, else the current stall pattern
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            hold_seen <= 1'b0;
            hold_cnt  <= 0;
            rx_pat    <= 16'hACE1;
        end else if (hold_trig != hold_seen) begin
            hold_seen <= hold_trig;
            hold_cnt  <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 1'b0;
        end else begin
            rx_pat <= {rx_pat[14:0], rx_pat[15] ^ rx_pat[13] ^ rx_pat[12] ^ rx_pat[10]};
            case (rx_mode)
                RX_ALWAYS: begin
                    m_tready <= 1'b1;
                end
                RX_COIN: begin
                    m_tready <= ($urandom_range(0, 1) == 1);
                end
                RX_SPARSE: begin
                    m_tready <= ($urandom_range(0, 3) == 0);
                end
                default: begin
                    m_tready <= rx_pat[0];
                end
            endcase
        end
    end

    // apb write: setup then access, register taken at the access edge
    task automatic cfg_write(input logic reg_sel, input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        if (reg_sel == DBS_REG_ORDER) begin
            pwdata <= {16'($urandom_range(0, 16'hFFFF)), 12'($urandom_range(0, 12'hFFF)),
                       value[3:0]};
        end else begin
            pwdata <= {16'($urandom_range(0, 16'hFFFF)), value};
        end
        @(posedge aclk);
        penable <= 1'b1;
        do begin
            @(posedge aclk);
        end while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_sel == DBS_REG_ORDER) begin
            model_order = value[3:0];
        end else begin
            model_inv = value;
        end
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        while (pending_basis.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // registers change only with the block idle
    task automatic set_config(input logic [3:0] order, input logic [15:0] inv);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_write(DBS_REG_ORDER, {12'd0, order});
        cfg_write(DBS_REG_INV, inv);
        settings_used++;
    endtask

    // offer one point, bursts separated by random gaps
    task automatic send_point(input logic [15:0] xc, input logic [15:0] yc);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0 || !gaps_on) ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {yc, xc};
        do begin
            @(posedge aclk);
        end while (!s_tready);
    endtask

    task automatic sender_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0:       return 16'h8000;
                    1:       return 16'h7FFF;
                    2:       return 16'h0000;
                    default: return 16'hFFFF;
                endcase
            end
            1, 2, 3: begin
                return 16'($urandom_range(0, 1023) - 512);
            end
            default: begin
                return 16'($urandom());
            end
        endcase
    endfunction

    function automatic logic [3:0] rand_order();
        case ($urandom_range(0, 11))
            0:       return 4'd0;
            1:       return 4'd9;
            2:       return 4'd15;
            3:       return 4'd8;
            4:       return 4'd1;
            default: return 4'($urandom_range(1, 8));
        endcase
    endfunction

    function automatic logic [15:0] rand_inv();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'd1;
            2:       return 16'hFFFF;
            3:       return 16'd256;
            4, 5:    return 16'($urandom_range(1, 1024));
            default: return 16'($urandom());
        endcase
    endfunction

    // points under the register reset values
    task automatic test_reset_defaults();
        rx_mode <= RX_ALWAYS;
        send_point(16'h0000, 16'h0000);
        send_point(16'h0100, 16'hFF00);
        send_point(16'h7FFF, 16'h8000);
        sender_idle();
    endtask

    // field extremes, quadrant edges, order clamping, zero and tiny reciprocal
    task automatic test_directed_cases();
        rx_mode <= RX_COIN;
        set_config(4'd1, 16'd256);
        send_point(16'h8000, 16'h7FFF);
        sender_idle();
        // quarter and half turn boundaries
        set_config(4'd8, 16'd256);
        send_point(16'h0080, 16'h0040);
        send_point(16'h0100, 16'h0080);
        send_point(16'hFF80, 16'hFFFF);
        sender_idle();
        set_config(4'd8, 16'hFFFF);
        send_point(16'h7FFF, 16'h8000);
        send_point(16'h0001, 16'hFFFF);
        sender_idle();
        // order zero acts as one
        set_config(4'd0, 16'd1);
        send_point(16'h3039, 16'hCFC7);
        sender_idle();
        // order above the cap with zero reciprocal
        set_config(4'd9, 16'd0);
        send_point(16'h7FFF, 16'h0309);
        sender_idle();
        set_config(4'd15, 16'd40000);
        send_point(16'h1234, 16'hEDCB);
        send_point(16'hFFFF, 16'h0000);
        sender_idle();
        set_config(4'd2, 16'd128);
        send_point(16'h5555, 16'hAAAA);
        send_point(16'hAAAA, 16'h5555);
        sender_idle();
    endtask

    // random points over several register settings and stall patterns
    task automatic test_random_points();
        int n;
        for (int ph = 0; ph < 10; ph++) begin
            set_config(rand_order(), rand_inv());
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            gaps_on = ($urandom_range(0, 3) != 0);
            n = $urandom_range(14, 22);
            for (int i = 0; i < n; i++) begin
                send_point(rand_coord(), rand_coord());
            end
            sender_idle();
        end
        gaps_on = 1'b1;
    endtask

    // receiver holds off while points keep coming, input must stall
    task automatic test_output_hold();
        set_config(4'd8, rand_inv());
        rx_mode   <= RX_ALWAYS;
        hold_trig <= ~hold_trig;
        gaps_on = 1'b0;
        for (int i = 0; i < 10; i++) begin
            send_point(rand_coord(), rand_coord());
        end
        sender_idle();
        gaps_on = 1'b1;
    endtask

    // sender stops until every value is out, then resumes
    task automatic test_drain_pause();
        set_config(4'($urandom_range(2, 6)), rand_inv());
        rx_mode <= RX_PATTERN;
        for (int i = 0; i < 6; i++) begin
            send_point(rand_coord(), rand_coord());
        end
        sender_idle();
        wait_drained();
        for (int i = 0; i < 6; i++) begin
            send_point(rand_coord(), rand_coord());
        end
        sender_idle();
    endtask

    initial begin
        build_cos_rom();
        model_order = DBS_ORDER_RST;
        model_inv   = DBS_INV_RST;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_directed_cases();
        test_random_points();
        test_output_hold();
        test_drain_pause();

        // drain and watch for stray values
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (pending_basis.size() != 0) begin
            $display("%0d basis values never arrived", pending_basis.size());
            bad_results += pending_basis.size();
        end

        $display("covered %0d points, %0d basis values, %0d register settings",
                 points_taken, values_checked, settings_used);
        $display("orders 0..15 with clamping, reciprocals 0..65535, hold-off and drain pauses");
        if (bad_results == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
hdl/dbs_pkg.sv
hdl/dbs_seq.sv
hdl/dbs_phase.sv
hdl/dbs_cos.sv
hdl/dbs_mul.sv
hdl/dct_basis_sampler.sv
verif/tb.sv
